// ===== rtl/sorted_priority_queue_macros.svh =====
// Assertion macros for the sorted priority queue checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted priority queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted priority queue: next-cycle check failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by the cell, the top level and the checker; no dependencies.
`default_nettype none
package spq_pkg;
	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [4:0] OCC_FULL = 5'(CAPACITY);

	typedef logic signed [31:0] key_t;
	typedef logic [31:0] data_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} spq_op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} spq_status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} spq_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: a row of spq_cell slots, the
// entry counter and the result register. Depends on spq_pkg and spq_cell.
//
// Usage:
// Requests arrive on in_valid / in_stall with opcode, key and payload.
// An insert places the entry in ascending key order, ahead of equal keys.
// A remove returns the smallest entry on out_key and out_payload.
// Every request gives exactly one result on out_valid / out_stall with
// status, out_key, out_payload and the occupancy after the request.
// An insert into a full store is dropped with status full; a remove from
// an empty store reports status empty. Both return zero key and payload.
// The result appears in the cycle after acceptance. One request is taken
// per cycle, since every cell compares against the new key in parallel and
// shifts in the same cycle. The single result register sets that figure:
// while a result is held and out_stall is high, in_stall is high too, and
// the result and the store hold still.
// Reset empties the store at once; no clearing pass is needed.
`default_nettype none
module sorted_priority_queue import spq_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         opcode,
	input  key_t        key,
	input  data_t       payload,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output key_t        out_key,
	output data_t       out_payload,
	output logic [4:0]  occupancy
);
	count_t      count_q;
	count_t      count_next;
	logic        out_valid_q;
	spq_status_t status_q;
	spq_status_t status_next;
	key_t        out_key_q;
	data_t       out_payload_q;
	logic [4:0]  occupancy_q;
	logic [31:0] count_wide;
	logic        accept;
	logic        full;
	logic        empty;
	spq_cmd_t    cmd;

	logic  less   [CAPACITY];
	key_t  c_key  [CAPACITY];
	data_t c_pay  [CAPACITY];

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;
	assign full = (count_q == count_t'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		cmd.ins = 1'b0;
		cmd.rem = 1'b0;
		count_next = count_q;
		status_next = ST_INSERTED;
		if (opcode == OP_INSERT) begin
			if (full) begin
				status_next = ST_FULL;
			end else begin
				cmd.ins = accept;
				count_next = count_q + count_t'(1);
			end
		end else begin
			if (empty) begin
				status_next = ST_EMPTY;
			end else begin
				cmd.rem = accept;
				status_next = ST_REMOVED;
				count_next = count_q - count_t'(1);
			end
		end
	end

	assign count_wide = 32'(count_next);

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic  p_less;
			key_t  p_key;
			data_t p_pay;
			key_t  n_key;
			data_t n_pay;
			if (i == 0) begin : g_first
				assign p_less = 1'b1;
				assign p_key = key;
				assign p_pay = payload;
			end else begin : g_mid
				assign p_less = less[i-1];
				assign p_key = c_key[i-1];
				assign p_pay = c_pay[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign n_key = c_key[i];
				assign n_pay = c_pay[i];
			end else begin : g_inner
				assign n_key = c_key[i+1];
				assign n_pay = c_pay[i+1];
			end
			spq_cell u_cell (
				.clk          (clk),
				.cmd          (cmd),
				.valid        (count_t'(i) < count_q),
				.new_key      (key),
				.new_payload  (payload),
				.prev_less    (p_less),
				.prev_key     (p_key),
				.prev_payload (p_pay),
				.next_key     (n_key),
				.next_payload (n_pay),
				.less         (less[i]),
				.cell_key     (c_key[i]),
				.cell_payload (c_pay[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_next;
			occupancy_q <= count_wide[4:0];
			if (cmd.rem) begin
				out_key_q <= c_key[0];
				out_payload_q <= c_pay[0];
			end else begin
				out_key_q <= '0;
				out_payload_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_key = out_key_q;
	assign out_payload = out_payload_q;
	assign occupancy = occupancy_q;
endmodule
`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted shift register: holds a key and payload and
// exchanges them with its neighbors. Depends on spq_pkg.
`default_nettype none
module spq_cell import spq_pkg::*; (
	input  wire       clk,
	input  spq_cmd_t  cmd,
	input  wire       valid,
	input  key_t      new_key,
	input  data_t     new_payload,
	input  wire       prev_less,
	input  key_t      prev_key,
	input  data_t     prev_payload,
	input  key_t      next_key,
	input  data_t     next_payload,
	output logic      less,
	output key_t      cell_key,
	output data_t     cell_payload
);
	key_t  key_q;
	data_t payload_q;

	assign less = valid && (key_q < new_key);
	assign cell_key = key_q;
	assign cell_payload = payload_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!less) begin
				if (prev_less) begin
					key_q <= new_key;
					payload_q <= new_payload;
				end else begin
					key_q <= prev_key;
					payload_q <= prev_payload;
				end
			end
		end else if (cmd.rem) begin
			key_q <= next_key;
			payload_q <= next_payload;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_macros.svh.
`default_nettype none
`include "sorted_priority_queue_macros.svh"
module spq_checker import spq_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [1:0]  status,
	input wire [31:0] out_key,
	input wire [31:0] out_payload,
	input wire [4:0]  occupancy
);
	`SPQ_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(status) && $stable(occupancy))
	`SPQ_ASSERT_IMPL(a_full_count, out_valid && status == ST_FULL, occupancy == OCC_FULL)
	`SPQ_ASSERT_IMPL(a_empty_count, out_valid && status == ST_EMPTY, occupancy == 5'd0)
	`SPQ_ASSERT_IMPL(a_zero_data, out_valid && status != ST_REMOVED, out_key == 32'd0 && out_payload == 32'd0)
	`SPQ_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid)
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
`default_nettype wire
